// File: hdl/cpw_pkg.sv
// Shared types and constants of the core power weight estimator.
package cpw_pkg;

    localparam int MAX_CORES   = 8;
    localparam int MAX_DOMAINS = 4;
    localparam int MAX_STATES  = 16;

    localparam int FREQ_W   = 22;
    localparam int WEIGHT_W = 24;
    localparam int UTIL_W   = 15;
    localparam int MV_W     = 16;
    localparam int LOAD_W   = 40;
    localparam int MA_W     = 24;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int TBL_AW   = 6;
    localparam int NUM_W    = 47;
    localparam int PROD_W   = 62;
    localparam int DIVD_W   = 64;
    localparam int DIVS_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_UNIT = 1'b1;

    typedef enum logic [1:0] {
        KIND_TABLE  = 2'd0,
        KIND_DOMAIN = 2'd1,
        KIND_MAP    = 2'd2,
        KIND_SAMPLE = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK0,
        ST_CHKL,
        ST_SCAN,
        ST_MUL1,
        ST_MUL2,
        ST_MULU,
        ST_SDIV,
        ST_SWAIT,
        ST_CUR,
        ST_CAL1,
        ST_CAL2,
        ST_CWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   freq;
        logic [WEIGHT_W-1:0] weight;
    } tbl_entry_t;

endpackage

// File: hdl/cpw_if.sv
// Valid/ready channel interfaces for samples in and results out.
interface cpw_in_if;
    import cpw_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [1:0]          domain;
    logic [3:0]          entry;
    logic [4:0]          state_count;
    logic [2:0]          core;
    logic [FREQ_W-1:0]   freq_khz;
    logic [WEIGHT_W-1:0] weight;
    logic [UTIL_W-1:0]   util_pct;
    logic [MV_W-1:0]     voltage_mv;
    logic                last;

    modport source (output valid, kind, domain, entry, state_count, core, freq_khz,
                    weight, util_pct, voltage_mv, last, input ready);
    modport sink (input valid, kind, domain, entry, state_count, core, freq_khz,
                  weight, util_pct, voltage_mv, last, output ready);
endinterface

interface cpw_out_if;
    import cpw_pkg::*;
    logic              valid;
    logic              ready;
    logic [LOAD_W-1:0] load_units;
    logic [MA_W-1:0]   cpu_milliamp;
    logic              current_valid;

    modport source (output valid, load_units, cpu_milliamp, current_valid, input ready);
    modport sink (input valid, load_units, cpu_milliamp, current_valid, output ready);
endinterface

// File: hdl/core_power_weight_estimator_top.sv
// Core power weight estimator: the top level with its control sequencer.
//
// Input channel in_ch carries set-up requests (table entries, domain info,
// core-to-domain mappings) and core samples; output channel out_ch carries one
// result for each sample marked last. Registers are written through cfg_we,
// cfg_index and cfg_data; write them only while the block is idle, which the
// block itself does not enforce. A set-up request or a skipped sample not
// marked last leaves the sequencer idle, ready for the next request. A sample
// whose domain has table entries walks its domain table in the energy table
// memory, one entry read per cycle through a registered read port, then runs
// a 64-step serial divide; the table walk covers up to 16 entries. A last
// sample adds the current estimate: calibrated, through a second divide, or
// none when no current is available. One request is in flight at a time;
// in_ch.ready is high while idle. The result sits in an output register; a new
// request is taken while it waits, and a sequencer that reaches a new result
// holds until out_ch frees. Reset clears the mappings, domain info, the running
// load and the registers; table memory content is undefined until written.
module core_power_weight_estimator_top
    import cpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    cpw_in_if.sink               in_ch,
    cpw_out_if.source            out_ch
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    calib_reg;
    logic                micro_reg;
    logic [1:0]          core_dom_reg [MAX_CORES];
    logic                core_asg_reg [MAX_CORES];
    logic [4:0]          dom_cnt_reg  [MAX_DOMAINS];
    logic [WEIGHT_W-1:0] dom_flat_reg [MAX_DOMAINS];
    logic [LOAD_W-1:0]   load_sum_reg;
    logic                out_valid_reg;

    logic [FREQ_W-1:0]   freq_reg;
    logic [UTIL_W-1:0]   util_reg;
    logic [MV_W-1:0]     mv_reg;
    logic                last_reg;
    logic [1:0]          dom_reg;
    logic [4:0]          cnt_reg;
    logic [3:0]          idx_reg;
    logic [FREQ_W-1:0]   lo_f_reg;
    logic [WEIGHT_W-1:0] lo_w_reg;
    logic [FREQ_W-1:0]   hi_f_reg;
    logic [WEIGHT_W-1:0] hi_w_reg;
    logic [WEIGHT_W-1:0] last_w_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [FREQ_W-1:0]   den_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [55:0]         p1_reg;
    logic [MA_W-1:0]     ma_reg;
    logic                cv_reg;
    logic [LOAD_W-1:0]   out_load_reg;
    logic [MA_W-1:0]     out_ma_reg;
    logic                out_cv_reg;

    logic                accept;
    logic                in_sample;
    logic                skip;
    logic [1:0]          smp_dom;
    logic                smp_asg;
    logic [4:0]          smp_cnt;
    logic                out_free;
    logic                f_le_rd;
    logic                f_ge_rd;
    logic                scan_end;
    logic [49:0]         load_x1000;
    logic [28:0]         den100;
    logic [DIVD_W:0]     acc_sum;
    logic [48:0]         cal_sum;

    logic                tbl_we;
    tbl_entry_t          tbl_wdata;
    logic                tbl_re;
    logic [TBL_AW-1:0]   tbl_raddr;
    tbl_entry_t          tbl_rdata;

    logic                div_start;
    logic [DIVD_W-1:0]   div_dividend;
    logic [DIVS_W-1:0]   div_divisor;
    logic                div_busy;
    logic                div_done;
    logic [DIVD_W-1:0]   div_q;

    assign accept    = in_ch.valid && in_ch.ready;
    assign in_sample = in_ch.kind == KIND_SAMPLE;
    assign smp_dom   = core_dom_reg[in_ch.core];
    assign smp_asg   = core_asg_reg[in_ch.core];
    assign smp_cnt   = dom_cnt_reg[smp_dom];
    assign skip      = in_ch.util_pct == '0 || in_ch.freq_khz == '0 || !smp_asg;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign f_le_rd   = freq_reg <= tbl_rdata.freq;
    assign f_ge_rd   = freq_reg >= tbl_rdata.freq;
    assign scan_end  = ({1'b0, idx_reg} + 5'd1) == cnt_reg;
    assign load_x1000 = 50'(load_sum_reg) * 50'd1000;
    assign den100    = 29'(den_reg) * 29'd100;
    assign acc_sum   = {1'b0, DIVD_W'(load_sum_reg)} + {1'b0, div_q};
    assign cal_sum   = 49'(calib_reg * load_sum_reg[39:24]) + 49'(p1_reg[55:24]);

    assign tbl_we    = accept && in_ch.kind == KIND_TABLE;
    assign tbl_wdata = '{freq: in_ch.freq_khz, weight: in_ch.weight};

    cpw_table u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr ({in_ch.domain, in_ch.entry}),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    cpw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_sample)
                begin
                    if (skip)
                        state_next = in_ch.last ? ST_CUR : ST_IDLE;
                    else if (smp_cnt == '0)
                        state_next = ST_MULU;
                    else
                        state_next = ST_CHK0;
                end
            end
            ST_CHK0:  state_next = f_le_rd ? ST_MULU : ST_CHKL;
            ST_CHKL:  state_next = f_ge_rd ? ST_MULU : ST_SCAN;
            ST_SCAN:
            begin
                if (freq_reg > tbl_rdata.freq)
                    state_next = scan_end ? ST_MULU : ST_SCAN;
                else if (tbl_rdata.freq <= lo_f_reg || freq_reg <= lo_f_reg)
                    state_next = ST_MULU;
                else
                    state_next = ST_MUL1;
            end
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_MULU;
            ST_MULU:  state_next = ST_SDIV;
            ST_SDIV:  state_next = ST_SWAIT;
            ST_SWAIT:
            begin
                if (div_done)
                    state_next = last_reg ? ST_CUR : ST_IDLE;
            end
            ST_CUR:
            begin
                if (calib_reg != '0)
                    state_next = ST_CAL1;
                else if (mv_reg > MV_W'(100))
                    state_next = ST_CWAIT;
                else
                    state_next = ST_OUT;
            end
            ST_CAL1:  state_next = ST_CAL2;
            ST_CAL2:  state_next = ST_OUT;
            ST_CWAIT: state_next = div_done ? ST_OUT : ST_CWAIT;
            ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ch.ready  = 1'b0;
        tbl_re       = 1'b0;
        tbl_raddr    = '0;
        div_start    = 1'b0;
        div_dividend = {2'b0, prod_reg};
        div_divisor  = {3'b0, den100};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                tbl_re      = 1'b1;
                tbl_raddr   = {smp_dom, 4'd0};
            end
            ST_CHK0:
            begin
                tbl_re    = 1'b1;
                tbl_raddr = {dom_reg, 4'(cnt_reg - 5'd1)};
            end
            ST_CHKL:
            begin
                tbl_re    = 1'b1;
                tbl_raddr = {dom_reg, 4'd1};
            end
            ST_SCAN:
            begin
                tbl_re    = 1'b1;
                tbl_raddr = {dom_reg, 4'(idx_reg + 4'd1)};
            end
            ST_SDIV:
            begin
                div_start = 1'b1;
            end
            ST_CUR:
            begin
                div_start    = calib_reg == '0 && mv_reg > MV_W'(100);
                div_dividend = micro_reg ? DIVD_W'(load_sum_reg) : DIVD_W'(load_x1000);
                div_divisor  = {8'b0, mv_reg, 8'b0};
            end
            default:
            begin
                tbl_re = 1'b0;
            end
        endcase
    end

    // Control state and set-up storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            calib_reg     <= '0;
            micro_reg     <= 1'b0;
            load_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CORES; i++)
            begin
                core_dom_reg[i] <= '0;
                core_asg_reg[i] <= 1'b0;
            end
            for (int i = 0; i < MAX_DOMAINS; i++)
            begin
                dom_cnt_reg[i]  <= '0;
                dom_flat_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CALIB_SCALE: calib_reg <= cfg_data;
                    CFG_WEIGHT_UNIT: micro_reg <= cfg_data[0];
                    default:         calib_reg <= calib_reg;
                endcase
            end
            if (accept && in_ch.kind == KIND_DOMAIN)
            begin
                dom_cnt_reg[in_ch.domain]  <= in_ch.state_count > 5'(MAX_STATES)
                                            ? 5'(MAX_STATES) : in_ch.state_count;
                dom_flat_reg[in_ch.domain] <= in_ch.weight;
            end
            if (accept && in_ch.kind == KIND_MAP)
            begin
                core_dom_reg[in_ch.core] <= in_ch.domain;
                core_asg_reg[in_ch.core] <= 1'b1;
            end
            // saturate the running load
            if (state_reg == ST_SWAIT && div_done)
            begin
                load_sum_reg <= acc_sum[DIVD_W:LOAD_W] != '0 ? '1 : acc_sum[LOAD_W-1:0];
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                load_sum_reg  <= '0;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_sample)
                begin
                    freq_reg <= in_ch.freq_khz;
                    util_reg <= in_ch.util_pct;
                    mv_reg   <= in_ch.voltage_mv;
                    last_reg <= in_ch.last;
                    dom_reg  <= smp_dom;
                    cnt_reg  <= smp_cnt;
                    num_reg  <= NUM_W'(dom_flat_reg[smp_dom]);
                    den_reg  <= FREQ_W'(1);
                end
            end
            ST_CHK0:
            begin
                lo_f_reg <= tbl_rdata.freq;
                lo_w_reg <= tbl_rdata.weight;
                num_reg  <= NUM_W'(tbl_rdata.weight);
            end
            ST_CHKL:
            begin
                last_w_reg <= tbl_rdata.weight;
                num_reg    <= NUM_W'(tbl_rdata.weight);
                idx_reg    <= 4'd1;
            end
            ST_SCAN:
            begin
                hi_f_reg <= tbl_rdata.freq;
                hi_w_reg <= tbl_rdata.weight;
                if (freq_reg > tbl_rdata.freq)
                begin
                    lo_f_reg <= tbl_rdata.freq;
                    lo_w_reg <= tbl_rdata.weight;
                    idx_reg  <= idx_reg + 4'd1;
                    num_reg  <= NUM_W'(last_w_reg);
                end
                else
                begin
                    num_reg <= NUM_W'(lo_w_reg);
                end
            end
            ST_MUL1:
            begin
                num_reg <= NUM_W'(NUM_W'(lo_w_reg) * NUM_W'(hi_f_reg - freq_reg));
                den_reg <= hi_f_reg - lo_f_reg;
            end
            ST_MUL2:
            begin
                num_reg <= num_reg + NUM_W'(NUM_W'(hi_w_reg) * NUM_W'(freq_reg - lo_f_reg));
            end
            ST_MULU:
            begin
                prod_reg <= PROD_W'(util_reg) * PROD_W'(num_reg);
            end
            ST_CUR:
            begin
                ma_reg <= '0;
                cv_reg <= calib_reg != '0 || mv_reg > MV_W'(100);
            end
            ST_CAL1:
            begin
                p1_reg <= calib_reg * load_sum_reg[23:0];
            end
            ST_CAL2:
            begin
                ma_reg <= cal_sum[48:MA_W] != '0 ? '1 : cal_sum[MA_W-1:0];
            end
            ST_CWAIT:
            begin
                if (div_done)
                    ma_reg <= div_q[DIVD_W-1:MA_W] != '0 ? '1 : div_q[MA_W-1:0];
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load_reg <= load_sum_reg;
                    out_ma_reg   <= ma_reg;
                    out_cv_reg   <= cv_reg;
                end
            end
            default:
            begin
                p1_reg <= p1_reg;
            end
        endcase
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.load_units    = out_load_reg;
    assign out_ch.cpu_milliamp  = out_ma_reg;
    assign out_ch.current_valid = out_cv_reg;

`ifndef NO_ASSERTIONS
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_cur_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CUR |-> last_reg)
        else $error("current computed for a sample not marked last");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> out_valid_reg && load_sum_reg == '0)
        else $error("result not posted or load not cleared");

    a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAIT || state_reg == ST_CWAIT) && !div_done |-> div_busy)
        else $error("waiting on an idle divider");
`endif

endmodule

// File: hdl/cpw_table.sv
// Energy table memory: one write port, one registered read port.
module cpw_table
    import cpw_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [TBL_AW-1:0] waddr,
    input  tbl_entry_t        wdata,
    input  logic              re,
    input  logic [TBL_AW-1:0] raddr,
    output tbl_entry_t        rdata
);

    tbl_entry_t mem [2**TBL_AW];
    tbl_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/cpw_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module cpw_div
    import cpw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVS_W:0]   rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] dsr_reg;
    logic [DIVS_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg[DIVS_W-1:0], quo_reg[DIVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sh - {1'b0, dsr_reg} : rem_sh;
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: tb/core_power_weight_estimator_top_tb.sv
// Testbench for the core power weight estimator: directed and random requests with a scoreboard.
`timescale 1ns / 1ps
module core_power_weight_estimator_top_tb;
    import cpw_pkg::*;

    typedef struct {
        logic [LOAD_W-1:0] load;
        logic [MA_W-1:0]   ma;
        logic              cv;
    } estimate_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    cpw_in_if in_ch();
    cpw_out_if out_ch();

    core_power_weight_estimator_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [31:0] m_scale;
    logic m_micro;
    logic [1:0] m_map [MAX_CORES];
    logic m_assigned [MAX_CORES];
    logic [FREQ_W-1:0] m_freq [MAX_DOMAINS*MAX_STATES];
    logic [WEIGHT_W-1:0] m_wt [MAX_DOMAINS*MAX_STATES];
    logic [4:0] m_count [MAX_DOMAINS];
    logic [WEIGHT_W-1:0] m_flat [MAX_DOMAINS];
    logic [LOAD_W-1:0] m_load;

    estimate_t expected_estimates[$];
    int errors = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;
    localparam int QUIET_LIMIT = 20000;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = '0; in_ch.domain = '0; in_ch.entry = '0; in_ch.state_count = '0;
        in_ch.core = '0; in_ch.freq_khz = '0; in_ch.weight = '0; in_ch.util_pct = '0;
        in_ch.voltage_mv = '0; in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
    end

    task automatic weight_frac(input logic [2:0] c, input logic [FREQ_W-1:0] f,
                               output logic [63:0] num, output logic [63:0] den);
        int d;
        int n;
        int b;
        logic [63:0] flo, fhi;
        num = 0;
        den = 1;
        if (!m_assigned[c])
            return;
        d = m_map[c];
        n = m_count[d];
        b = d * MAX_STATES;
        if (n == 0) begin
            num = m_flat[d];
            return;
        end
        if (f <= m_freq[b]) begin
            num = m_wt[b];
            return;
        end
        if (f >= m_freq[b+n-1]) begin
            num = m_wt[b+n-1];
            return;
        end
        for (int i = 1; i < n; i++) begin
            if (f > m_freq[b+i])
                continue;
            flo = m_freq[b+i-1];
            fhi = m_freq[b+i];
            if (fhi <= flo || f <= flo) begin
                num = m_wt[b+i-1];
                return;
            end
            num = 64'(m_wt[b+i-1]) * (fhi - f) + 64'(m_wt[b+i]) * (f - flo);
            den = fhi - flo;
            return;
        end
        num = m_wt[b+n-1];
    endtask

    task automatic predict_request(input logic [1:0] kind, input logic [1:0] dom,
            input logic [3:0] ent, input logic [4:0] cnt, input logic [2:0] c,
            input logic [FREQ_W-1:0] f, input logic [WEIGHT_W-1:0] w,
            input logic [UTIL_W-1:0] u, input logic [MV_W-1:0] mv, input logic lst);
        logic [63:0] num, den, add, ma;
        logic [127:0] prod;
        estimate_t e;
        case (kind_t'(kind))
            KIND_TABLE: begin
                m_freq[dom*MAX_STATES+ent] = f;
                m_wt[dom*MAX_STATES+ent] = w;
            end
            KIND_DOMAIN: begin
                m_count[dom] = (cnt > MAX_STATES) ? 5'(MAX_STATES) : cnt;
                m_flat[dom] = w;
            end
            KIND_MAP: begin
                m_map[c] = dom;
                m_assigned[c] = 1'b1;
            end
            default: begin
                if (u != 0 && f != 0) begin
                    weight_frac(c, f, num, den);
                    prod = 128'(u) * num;
                    add = 64'(prod / (128'(den) * 100));
                    if (add > 64'(40'hFF_FFFF_FFFF) - m_load)
                        m_load = '1;
                    else
                        m_load = m_load + add;
                end
                if (lst) begin
                    ma = 0;
                    e.cv = 1'b0;
                    if (m_scale != 0) begin
                        ma = 64'(m_scale) * (m_load >> 24)
                           + ((64'(m_scale) * m_load[23:0]) >> 24);
                        e.cv = 1'b1;
                    end else if (mv > 100) begin
                        if (m_micro)
                            ma = m_load / (64'(mv) * 256);
                        else
                            ma = (64'(m_load) * 1000) / (64'(mv) * 256);
                        e.cv = 1'b1;
                    end
                    if (ma > 64'hFF_FFFF)
                        ma = 64'hFF_FFFF;
                    e.load = m_load;
                    e.ma = ma[MA_W-1:0];
                    expected_estimates.push_back(e);
                    m_load = 0;
                end
            end
        endcase
    endtask

    // valid stays high after an accepted request; it drops only while idling or draining
    task automatic send_request(input logic [1:0] kind, input logic [1:0] dom,
            input logic [3:0] ent, input logic [4:0] cnt, input logic [2:0] c,
            input logic [FREQ_W-1:0] f, input logic [WEIGHT_W-1:0] w,
            input logic [UTIL_W-1:0] u, input logic [MV_W-1:0] mv, input logic lst);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind; in_ch.domain <= dom; in_ch.entry <= ent;
        in_ch.state_count <= cnt; in_ch.core <= c; in_ch.freq_khz <= f;
        in_ch.weight <= w; in_ch.util_pct <= u; in_ch.voltage_mv <= mv; in_ch.last <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_request(kind, dom, ent, cnt, c, f, w, u, mv, lst);
    endtask

    task automatic sample(input logic [2:0] c, input logic [FREQ_W-1:0] f,
                          input logic [UTIL_W-1:0] u, input logic [MV_W-1:0] mv,
                          input logic lst);
        send_request(KIND_SAMPLE, $urandom, $urandom, $urandom, c, f, $urandom, u, mv, lst);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_estimates.size() != 0)
            @(posedge clk);
        // a trailing set-up or non-last sample may still be in the sequencer
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CALIB_SCALE)
            m_scale = val;
        else
            m_micro = val[0];
    endtask

    always @(posedge clk) begin
        if (recv_stall > 0)
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk) begin
        estimate_t e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_estimates.size() == 0) begin
                $error("unexpected result load_units=%0h", out_ch.load_units);
                errors++;
            end else begin
                e = expected_estimates.pop_front();
                if (out_ch.load_units !== e.load) begin
                    $error("load_units expected %0h actual %0h", e.load, out_ch.load_units);
                    errors++;
                end
                if (out_ch.cpu_milliamp !== e.ma) begin
                    $error("cpu_milliamp expected %0h actual %0h", e.ma, out_ch.cpu_milliamp);
                    errors++;
                end
                if (out_ch.current_valid !== e.cv) begin
                    $error("current_valid expected %0b actual %0b", e.cv,
                           out_ch.current_valid);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("core_power_weight_estimator_top_tb: FAIL");
            $finish;
        end
    end

    // load a sorted table of n entries into domain d
    task automatic load_table(input logic [1:0] d, input int n, input bit extreme);
        logic [FREQ_W-1:0] f;
        f = $urandom_range(1000);
        for (int i = 0; i < n; i++) begin
            send_request(KIND_TABLE, d, i, 0, $urandom, f,
                         extreme ? 24'hFF_FFFF : $urandom, $urandom, $urandom, $urandom);
            f = f + $urandom_range(300000, 1);
        end
        send_request(KIND_DOMAIN, d, $urandom, n, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_directed();
        send_request(KIND_DOMAIN, 0, 0, 0, 0, 0, 24'hFF_FFFF, 0, 0, 0);
        send_request(KIND_MAP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        sample(1, 1000, 25600, 3700, 1'b1);           // unassigned core
        sample(0, 0, 25600, 3700, 1'b0);              // skipped: zero freq
        sample(0, 22'h3F_FFFF, 0, 3700, 1'b1);        // skipped last still reports
        sample(0, 22'h3F_FFFF, 25600, 100, 1'b1);     // low voltage
        sample(0, 5, 15'h7FFF, 16'hFFFF, 1'b1);
        load_table(1, 3, 1'b0);
        send_request(KIND_DOMAIN, 1, 0, 5'd31, 0, 0, 0, 0, 0, 0); // count saturates
        for (int i = 3; i < MAX_STATES; i++)
            send_request(KIND_TABLE, 1, i, 0, 0, 22'h3F_FFFF, 24'hFF_FFFF, 0, 0, 0);
        send_request(KIND_MAP, 1, 0, 0, 0, 0, 0, 0, 0, 0); // remap core 0
        sample(0, 1, 25600, 101, 1'b0);
        sample(0, 22'h3F_FFFF, 25600, 101, 1'b0);
        sample(0, 200000, 25600, 101, 1'b1);
    endtask

    task automatic random_phase(input int n_items);
        int k;
        for (int i = 0; i < n_items; i++) begin
            k = $urandom_range(99);
            if (k < 3)
                load_table($urandom, $urandom_range(MAX_STATES, 1), $urandom_range(9) == 0);
            else if (k < 5)
                send_request(KIND_DOMAIN, $urandom, $urandom, $urandom_range(31), $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (k < 9)
                send_request(KIND_MAP, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
            else if (k < 10)
                // unsorted or overwriting entry in a domain table
                send_request(KIND_TABLE, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
            else
                sample($urandom, ($urandom_range(9) == 0) ? $urandom : $urandom_range(2000000),
                       ($urandom_range(15) == 0) ? 15'($urandom) : $urandom_range(25600),
                       ($urandom_range(7) == 0) ? $urandom_range(120) : $urandom,
                       $urandom_range(3) == 0);
        end
    endtask

    task automatic test_setup_all();
        // every entry written so no random sample reads an unwritten one
        for (int d = 0; d < MAX_DOMAINS; d++)
            load_table(d, MAX_STATES, 1'b0);
        for (int c = 0; c < MAX_CORES; c++)
            send_request(KIND_MAP, $urandom, 0, 0, c, 0, 0, 0, 0, 0);
    endtask

    task automatic test_uncalibrated_milli();
        write_reg(CFG_CALIB_SCALE, 0);
        write_reg(CFG_WEIGHT_UNIT, 0);
        random_phase(320);
    endtask

    task automatic test_uncalibrated_micro();
        write_reg(CFG_WEIGHT_UNIT, 1);
        send_idle = 69;
        random_phase(280);
    endtask

    task automatic test_calibrated_max();
        write_reg(CFG_CALIB_SCALE, 32'hFFFF_FFFF);
        send_idle = 0;
        recv_stall = 69;
        random_phase(280);
    endtask

    task automatic test_calibrated_random();
        write_reg(CFG_CALIB_SCALE, $urandom);
        write_reg(CFG_WEIGHT_UNIT, 0);
        send_idle = 27;
        recv_stall = 27;
        random_phase(280);
        drain();   // sender holds off until every result has arrived
        write_reg(CFG_CALIB_SCALE, 1);
        random_phase(280);
    endtask

    initial begin
        m_scale = 0; m_micro = 0; m_load = 0;
        for (int i = 0; i < MAX_CORES; i++)
        begin
            m_map[i] = 0; m_assigned[i] = 0;
        end
        for (int i = 0; i < MAX_DOMAINS; i++)
        begin
            m_count[i] = 0; m_flat[i] = 0;
        end
        for (int i = 0; i < MAX_DOMAINS*MAX_STATES; i++)
        begin
            m_freq[i] = 0; m_wt[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_setup_all();
        test_uncalibrated_milli();
        test_uncalibrated_micro();
        test_calibrated_max();
        test_calibrated_random();
        drain();
        if (errors == 0 && expected_estimates.size() == 0)
            $display("core_power_weight_estimator_top_tb: PASS");
        else
            $display("core_power_weight_estimator_top_tb: FAIL");
        $finish;
    end
endmodule
